@@ src/thc_pkg.sv @@
// ----------------------------------------------------------------------------
// Twelve-hour clock package
// Shared types, mode codes, reset values and hour, minute and second stepping helpers.
// ----------------------------------------------------------------------------
package thc_pkg;

	localparam int TPS_W = 16;
	localparam int HOUR_W = 4;
	localparam int MS_W = 6;
	localparam int MODE_W = 2;

	localparam logic [MODE_W-1:0] MODE_SHOW = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SET_HOURS = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SET_MINUTES = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SET_SECONDS = 2'd3;

	localparam logic [TPS_W-1:0] TPS_RESET = 16'd1000;
	localparam logic [HOUR_W-1:0] HOUR_RESET = 4'd1;
	localparam logic [MS_W-1:0] MINUTE_RESET = 6'd58;
	localparam logic [MS_W-1:0] SECOND_RESET = 6'd0;
	localparam logic [MS_W-1:0] MS_LAST = 6'd59;
	localparam logic [MS_W:0] MS_WRAP = 7'd60;
	localparam logic [HOUR_W-1:0] HOUR_TOP = 4'd12;
	localparam logic [HOUR_W-1:0] HOUR_BEFORE_TOP = 4'd11;

	localparam int IN_BYTES_W = 8;
	localparam int OUT_BYTES_W = 40;

	// One sampled input word.
	typedef struct packed {
		logic tick;
		logic inc_button_n;
		logic dec_button_n;
		logic ok_button_n;
	} sample_t;

	// Hour together with its AM/PM flag, since they step as one.
	typedef struct packed {
		logic pm;
		logic [HOUR_W-1:0] hour;
	} hour_pm_t;

	// One result word before packing.
	typedef struct packed {
		logic [HOUR_W-1:0] hours;
		logic [MS_W-1:0] minutes;
		logic [MS_W-1:0] seconds;
		logic afternoon;
		logic [MODE_W-1:0] mode;
		logic commit_time;
	} result_t;

	function automatic hour_pm_t hour_up(input hour_pm_t x);
		hour_pm_t r;
		r = x;
		if (x.hour == HOUR_BEFORE_TOP) begin
			r.hour = HOUR_TOP;
			r.pm = ~x.pm;
		end else if (x.hour >= HOUR_TOP || x.hour == '0) begin
			r.hour = 4'd1;
		end else begin
			r.hour = x.hour + 4'd1;
		end
		return r;
	endfunction

	function automatic hour_pm_t hour_down(input hour_pm_t x);
		hour_pm_t r;
		r = x;
		if (x.hour == HOUR_TOP) begin
			r.hour = HOUR_BEFORE_TOP;
			r.pm = ~x.pm;
		end else if (x.hour <= 4'd1 || x.hour > HOUR_TOP) begin
			r.hour = HOUR_TOP;
		end else begin
			r.hour = x.hour - 4'd1;
		end
		return r;
	endfunction

	function automatic logic [MS_W-1:0] ms_up(input logic [MS_W-1:0] v);
		return (v < MS_LAST) ? v + 6'd1 : 6'd0;
	endfunction

	function automatic logic [MS_W-1:0] ms_down(input logic [MS_W-1:0] v);
		return (v > 6'd0 && v <= MS_LAST) ? v - 6'd1 : MS_LAST;
	endfunction

endpackage

@@ src/thc_core.sv @@
// ----------------------------------------------------------------------------
// Twelve-hour clock core
// Holds the time, mode and button history and applies one sample per enable.
// ----------------------------------------------------------------------------
module thc_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  thc_pkg::sample_t          sample,
	input  logic [thc_pkg::TPS_W-1:0] ticks_per_second,
	output thc_pkg::result_t          result
);
	import thc_pkg::*;

	logic [TPS_W-1:0] tick_count_q;
	hour_pm_t hp_q;
	logic [MS_W-1:0] minute_q;
	logic [MS_W-1:0] second_q;
	logic [MODE_W-1:0] mode_q;
	logic inc_was_q;
	logic dec_was_q;
	logic ok_was_q;

	logic [TPS_W-1:0] tc_inc;
	logic [TPS_W-1:0] tc_n;
	logic sec_hit;
	hour_pm_t hp_n;
	logic [MS_W-1:0] minute_n;
	logic [MS_W-1:0] second_n;
	logic [MS_W:0] sec_sum;
	logic [MS_W:0] min_sum;
	logic [MODE_W-1:0] mode_n;
	logic inc_now;
	logic dec_now;
	logic ok_now;

	assign inc_now = ~sample.inc_button_n;
	assign dec_now = ~sample.dec_button_n;
	assign ok_now = ~sample.ok_button_n;
	assign tc_inc = tick_count_q + 16'd1;
	// A register value of zero is below any count, so every tick is a second.
	assign sec_hit = sample.tick && (tc_inc >= ticks_per_second);
	assign sec_sum = {1'b0, second_q} + 7'd1;
	assign min_sum = {1'b0, minute_q} + 7'd1;

	always_comb begin
		tc_n = tick_count_q;
		hp_n = hp_q;
		minute_n = minute_q;
		second_n = second_q;
		mode_n = mode_q;

		if (sample.tick) begin
			tc_n = sec_hit ? '0 : tc_inc;
		end
		// Seconds only run in show mode; in a set mode the second is dropped.
		if (sec_hit && mode_q == MODE_SHOW) begin
			if (sec_sum >= MS_WRAP) begin
				second_n = '0;
				if (min_sum >= MS_WRAP) begin
					minute_n = '0;
					hp_n = hour_up(hp_q);
				end else begin
					minute_n = min_sum[MS_W-1:0];
				end
			end else begin
				second_n = sec_sum[MS_W-1:0];
			end
		end

		if (!ok_now && ok_was_q) begin
			mode_n = mode_q + 2'd1;
		end

		// INC and DEC act on the mode as it stands after the OK release.
		if (inc_now && !inc_was_q) begin
			unique case (mode_n)
				MODE_SET_HOURS: hp_n = hour_up(hp_n);
				MODE_SET_MINUTES: minute_n = ms_up(minute_n);
				MODE_SET_SECONDS: second_n = ms_up(second_n);
				default: ;
			endcase
		end
		if (dec_now && !dec_was_q) begin
			unique case (mode_n)
				MODE_SET_HOURS: hp_n = hour_down(hp_n);
				MODE_SET_MINUTES: minute_n = ms_down(minute_n);
				MODE_SET_SECONDS: second_n = ms_down(second_n);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			hp_q <= '{pm: 1'b0, hour: HOUR_RESET};
			minute_q <= MINUTE_RESET;
			second_q <= SECOND_RESET;
			mode_q <= MODE_SHOW;
			inc_was_q <= 1'b0;
			dec_was_q <= 1'b0;
			ok_was_q <= 1'b0;
		end else if (en) begin
			tick_count_q <= tc_n;
			hp_q <= hp_n;
			minute_q <= minute_n;
			second_q <= second_n;
			mode_q <= mode_n;
			inc_was_q <= inc_now;
			dec_was_q <= dec_now;
			ok_was_q <= ok_now;
		end
	end

	always_comb begin
		result.hours = hp_n.hour;
		result.minutes = minute_n;
		result.seconds = second_n;
		result.afternoon = hp_n.pm;
		result.mode = mode_n;
		result.commit_time = (mode_n != mode_q) && (mode_n == MODE_SHOW);
	end

endmodule

@@ src/twelve_hour_clock_with_set_mode_top.sv @@
// ----------------------------------------------------------------------------
// Twelve-hour clock with set mode
// Stream wrapper: input register, clock core and registered result word.
// ----------------------------------------------------------------------------
// An accepted input word is held in the input register; its result is registered.
// Throughput: one word per cycle while the output is not stalled.
// The result register frees as it is read, so the input keeps flowing.
// Reset clears the pipeline valids and sets time 01:58:00 AM, show mode,
// buttons released and ticks_per_second to 1000.
// ----------------------------------------------------------------------------
module twelve_hour_clock_with_set_mode_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [0] tick, [1] inc_button_n, [2] dec_button_n, [3] ok_button_n, [7:4] zero
	input  logic [thc_pkg::IN_BYTES_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [3:0] hours, [9:4] minutes, [15:10] seconds, [16] afternoon, [18:17] mode,
	// [22:19] hour_leds_n, [28:23] minute_leds_n, [34:29] second_leds_n,
	// [35] am_led_n, [36] pm_led_n, [37] commit_time, [39:38] zero
	output logic [thc_pkg::OUT_BYTES_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [thc_pkg::TPS_W-1:0]       cfg_data
);
	import thc_pkg::*;

	logic [TPS_W-1:0] tps_q;
	logic valid_s1;
	sample_t sample_s1;
	logic advance;
	logic core_en;
	result_t result;

	assign cfg_ready = 1'b1;
	assign advance = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign core_en = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tps_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1.tick <= s_tdata[0];
			sample_s1.inc_button_n <= s_tdata[1];
			sample_s1.dec_button_n <= s_tdata[2];
			sample_s1.ok_button_n <= s_tdata[3];
		end
	end

	thc_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (core_en),
		.sample           (sample_s1),
		.ticks_per_second (tps_q),
		.result           (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (core_en) begin
			m_tdata <= {2'b00, result.commit_time, ~result.afternoon, result.afternoon,
				~result.seconds, ~result.minutes, ~result.hours, result.mode,
				result.afternoon, result.seconds, result.minutes, result.hours};
		end
	end

	a_commit_in_show: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[37] |-> m_tdata[18:17] == MODE_SHOW)
		else $error("commit pulse outside show mode");

	a_hours_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3:0] >= 4'd1 && m_tdata[3:0] <= HOUR_TOP)
		else $error("hours out of range");

	a_ms_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[9:4] <= MS_LAST && m_tdata[15:10] <= MS_LAST)
		else $error("minutes or seconds out of range");

	a_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_tvalid && !m_tready |=> valid_s1 && $stable(sample_s1))
		else $error("input stage lost a word while the output stalled");

endmodule
